// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(expr), msg)

`endif

// ----- src/sst_pkg.sv -----
package sst_pkg;

  localparam int unsigned SESSIONS = 1024;
  localparam int unsigned SID_W    = 10;
  localparam int unsigned ST_W     = 4;
  localparam int unsigned ADDR_W   = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

  // Request kinds as carried on the input tuser
  localparam logic [2:0] KIND_TX_RW   = 3'd0;
  localparam logic [2:0] KIND_TX_LKUP = 3'd1;
  localparam logic [2:0] KIND_RX_RW   = 3'd2;
  localparam logic [2:0] KIND_TIMER   = 3'd3;
  localparam logic [2:0] KIND_IDLE    = 3'd4;

  localparam logic [ST_W-1:0] ST_CLOSED = '0;

  typedef enum logic [2:0] {
    RK_DONE     = 3'd0,
    RK_TX_RSP   = 3'd1,
    RK_LKUP_RSP = 3'd2,
    RK_RX_RSP   = 3'd3,
    RK_RELEASE  = 3'd4,
    RK_PARKED   = 3'd5,
    RK_REFUSED  = 3'd6
  } res_kind_e;

  typedef struct packed {
    logic [2:0]       kind;
    logic [SID_W-1:0] sid;
    logic             wr;
    logic [ST_W-1:0]  st;
  } req_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   wdata;
  } mem_op_t;

  typedef struct packed {
    res_kind_e        kind;
    logic [SID_W-1:0] sess;
    logic             rd;
  } res_t;

  // Store index of a session id; the modulus folds to a mask for a power of two.
  function automatic logic [ADDR_W-1:0] addr_of(input logic [SID_W-1:0] sid);
    logic [31:0] x;
    x = 32'(sid);
    return ADDR_W'(x % SESSIONS);
  endfunction

endpackage

// ----- src/tcp_session_state_table_unit.sv -----
// Path: input register, then lock/park decision with the state store access
//   into the result register.
// Throughput: one request per cycle; each request makes at most one store access
//   and one lock/park update, a stalled result holds the input side.
// Reset: locks and parking slots clear at once; the state store is then swept
//   to CLOSED over all SESSIONS (1024) entries, during which s_axis_tready is low.
module tcp_session_state_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sid[9:0], write[10], new_state[14:11]
  input  logic [2:0]  s_axis_tuser,   // kind[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_session[9:0], result_state[13:10]
  output logic [2:0]  m_axis_tuser    // result_kind[2:0]
);

  logic                      s1_valid_q;
  sst_pkg::req_t             s1_req_q;
  logic                      adv;
  logic                      busy;
  sst_pkg::mem_op_t          mem_op;
  sst_pkg::res_t             res;
  logic [sst_pkg::ST_W-1:0]  rdata;
  logic                      m_valid_q;
  sst_pkg::res_kind_e        m_kind_q;
  logic [sst_pkg::SID_W-1:0] m_sess_q;
  logic                      m_rd_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !busy && (!s1_valid_q || adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_req_q.kind <= s_axis_tuser;
      s1_req_q.sid  <= s_axis_tdata[9:0];
      s1_req_q.wr   <= s_axis_tdata[10];
      s1_req_q.st   <= s_axis_tdata[14:11];
    end
  end

  sst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (s1_req_q),
    .commit_i (s1_valid_q && adv),
    .mem_op_o (mem_op),
    .res_o    (res)
  );

  sst_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mem_op_i (mem_op),
    .busy_o   (busy),
    .rdata_o  (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      m_kind_q <= res.kind;
      m_sess_q <= res.sess;
      m_rd_q   <= res.rd;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {2'b00, (m_rd_q ? rdata : sst_pkg::ST_CLOSED), m_sess_q};

endmodule

// ----- src/sst_ctrl.sv -----
module sst_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sst_pkg::req_t    req_i,
  input  logic             commit_i,
  output sst_pkg::mem_op_t mem_op_o,
  output sst_pkg::res_t    res_o
);

  logic                      tx_lock_v_q, tx_lock_v_d;
  logic [sst_pkg::SID_W-1:0] tx_lock_s_q, tx_lock_s_d;
  logic                      rx_lock_v_q, rx_lock_v_d;
  logic [sst_pkg::SID_W-1:0] rx_lock_s_q, rx_lock_s_d;
  logic                      tx_park_v_q, tx_park_v_d;
  sst_pkg::req_t             tx_park_q, tx_park_d;
  logic                      rx_park_v_q, rx_park_v_d;
  sst_pkg::req_t             rx_park_q, rx_park_d;
  logic                      tm_park_v_q, tm_park_v_d;
  logic [sst_pkg::SID_W-1:0] tm_park_s_q, tm_park_s_d;

  // Work selected for execution this pass, direct or from a parking slot
  logic                      ex_tx, ex_rx, ex_tm;
  logic [sst_pkg::SID_W-1:0] ex_sid;
  logic                      ex_wr;
  logic [sst_pkg::ST_W-1:0]  ex_st;

  function automatic logic tx_blk(input logic rv, input logic [sst_pkg::SID_W-1:0] rs,
                                  input logic [sst_pkg::SID_W-1:0] s);
    return rv && (rs == s);
  endfunction

  always_comb begin
    ex_tx       = 1'b0;
    ex_rx       = 1'b0;
    ex_tm       = 1'b0;
    ex_sid      = req_i.sid;
    ex_wr       = req_i.wr;
    ex_st       = req_i.st;
    tx_park_v_d = tx_park_v_q;
    tx_park_d   = tx_park_q;
    rx_park_v_d = rx_park_v_q;
    rx_park_d   = rx_park_q;
    tm_park_v_d = tm_park_v_q;
    tm_park_s_d = tm_park_s_q;
    tx_lock_v_d = tx_lock_v_q;
    tx_lock_s_d = tx_lock_s_q;
    rx_lock_v_d = rx_lock_v_q;
    rx_lock_s_d = rx_lock_s_q;
    mem_op_o    = '0;
    res_o       = '{kind: sst_pkg::RK_DONE, sess: '0, rd: 1'b0};

    unique case (req_i.kind)
      sst_pkg::KIND_TX_RW: begin
        if (tx_park_v_q) begin
          res_o.kind = sst_pkg::RK_REFUSED;
        end else if (tx_blk(rx_lock_v_q, rx_lock_s_q, req_i.sid)) begin
          tx_park_v_d = 1'b1;
          tx_park_d   = req_i;
          res_o.kind  = sst_pkg::RK_PARKED;
        end else begin
          ex_tx = 1'b1;
        end
      end
      sst_pkg::KIND_TX_LKUP: begin
        mem_op_o.en   = 1'b1;
        mem_op_o.addr = sst_pkg::addr_of(req_i.sid);
        res_o.kind    = sst_pkg::RK_LKUP_RSP;
        res_o.rd      = 1'b1;
      end
      sst_pkg::KIND_RX_RW: begin
        if (rx_park_v_q) begin
          res_o.kind = sst_pkg::RK_REFUSED;
        end else if (tx_blk(tx_lock_v_q, tx_lock_s_q, req_i.sid)) begin
          rx_park_v_d = 1'b1;
          rx_park_d   = req_i;
          res_o.kind  = sst_pkg::RK_PARKED;
        end else begin
          ex_rx = 1'b1;
        end
      end
      sst_pkg::KIND_TIMER: begin
        if (tm_park_v_q) begin
          res_o.kind = sst_pkg::RK_REFUSED;
        end else if (tx_blk(rx_lock_v_q, rx_lock_s_q, req_i.sid) ||
                     tx_blk(tx_lock_v_q, tx_lock_s_q, req_i.sid)) begin
          tm_park_v_d = 1'b1;
          tm_park_s_d = req_i.sid;
          res_o.kind  = sst_pkg::RK_PARKED;
        end else begin
          ex_tm = 1'b1;
        end
      end
      sst_pkg::KIND_IDLE: begin
        // retry only the first occupied slot: tx, then rx, then timer
        priority if (tx_park_v_q) begin
          ex_sid = tx_park_q.sid;
          ex_wr  = tx_park_q.wr;
          ex_st  = tx_park_q.st;
          if (tx_blk(rx_lock_v_q, rx_lock_s_q, tx_park_q.sid)) begin
            res_o.kind = sst_pkg::RK_PARKED;
          end else begin
            tx_park_v_d = 1'b0;
            ex_tx       = 1'b1;
          end
        end else if (rx_park_v_q) begin
          ex_sid = rx_park_q.sid;
          ex_wr  = rx_park_q.wr;
          ex_st  = rx_park_q.st;
          if (tx_blk(tx_lock_v_q, tx_lock_s_q, rx_park_q.sid)) begin
            res_o.kind = sst_pkg::RK_PARKED;
          end else begin
            rx_park_v_d = 1'b0;
            ex_rx       = 1'b1;
          end
        end else if (tm_park_v_q) begin
          ex_sid = tm_park_s_q;
          if (tx_blk(rx_lock_v_q, rx_lock_s_q, tm_park_s_q) ||
              tx_blk(tx_lock_v_q, tx_lock_s_q, tm_park_s_q)) begin
            res_o.kind = sst_pkg::RK_PARKED;
          end else begin
            tm_park_v_d = 1'b0;
            ex_tm       = 1'b1;
          end
        end else begin
          res_o.kind = sst_pkg::RK_DONE;
        end
      end
      default: begin
        res_o.kind = sst_pkg::RK_REFUSED;
      end
    endcase

    mem_op_o.addr = (ex_tx || ex_rx || ex_tm) ? sst_pkg::addr_of(ex_sid) : mem_op_o.addr;

    if (ex_tx) begin
      mem_op_o.en = 1'b1;
      if (ex_wr) begin
        mem_op_o.we    = 1'b1;
        mem_op_o.wdata = ex_st;
        tx_lock_v_d    = 1'b0;
        res_o.kind     = sst_pkg::RK_DONE;
      end else begin
        tx_lock_v_d = 1'b1;
        tx_lock_s_d = ex_sid;
        res_o.kind  = sst_pkg::RK_TX_RSP;
        res_o.rd    = 1'b1;
      end
    end

    if (ex_rx) begin
      mem_op_o.en = 1'b1;
      if (ex_wr) begin
        mem_op_o.we    = 1'b1;
        mem_op_o.wdata = ex_st;
        rx_lock_v_d    = 1'b0;
        if (ex_st == sst_pkg::ST_CLOSED) begin
          res_o.kind = sst_pkg::RK_RELEASE;
          res_o.sess = ex_sid;
        end else begin
          res_o.kind = sst_pkg::RK_DONE;
        end
      end else begin
        rx_lock_v_d = 1'b1;
        rx_lock_s_d = ex_sid;
        res_o.kind  = sst_pkg::RK_RX_RSP;
        res_o.rd    = 1'b1;
      end
    end

    if (ex_tm) begin
      mem_op_o.en    = 1'b1;
      mem_op_o.we    = 1'b1;
      mem_op_o.wdata = sst_pkg::ST_CLOSED;
      res_o.kind     = sst_pkg::RK_RELEASE;
      res_o.sess     = ex_sid;
    end

    if (!commit_i) begin
      mem_op_o.en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_lock_v_q <= 1'b0;
      tx_lock_s_q <= '0;
      rx_lock_v_q <= 1'b0;
      rx_lock_s_q <= '0;
      tx_park_v_q <= 1'b0;
      tx_park_q   <= '0;
      rx_park_v_q <= 1'b0;
      rx_park_q   <= '0;
      tm_park_v_q <= 1'b0;
      tm_park_s_q <= '0;
    end else if (commit_i) begin
      tx_lock_v_q <= tx_lock_v_d;
      tx_lock_s_q <= tx_lock_s_d;
      rx_lock_v_q <= rx_lock_v_d;
      rx_lock_s_q <= rx_lock_s_d;
      tx_park_v_q <= tx_park_v_d;
      tx_park_q   <= tx_park_d;
      rx_park_v_q <= rx_park_v_d;
      rx_park_q   <= rx_park_d;
      tm_park_v_q <= tm_park_v_d;
      tm_park_s_q <= tm_park_s_d;
    end
  end

endmodule

// ----- src/sst_store.sv -----
module sst_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sst_pkg::mem_op_t          mem_op_i,
  output logic                      busy_o,
  output logic [sst_pkg::ST_W-1:0]  rdata_o
);

  logic [sst_pkg::ST_W-1:0]   mem_q [sst_pkg::SESSIONS];
  logic                       busy_q;
  logic [sst_pkg::ADDR_W-1:0] clr_q;
  logic [sst_pkg::ST_W-1:0]   rdata_q;

  localparam logic [sst_pkg::ADDR_W-1:0] LastAddr = sst_pkg::ADDR_W'(sst_pkg::SESSIONS - 1);

  // clearing pass: one entry per cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == LastAddr) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_q] <= sst_pkg::ST_CLOSED;
    end else if (mem_op_i.en && mem_op_i.we) begin
      mem_q[mem_op_i.addr] <= mem_op_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_op_i.en && !mem_op_i.we) begin
      rdata_q <= mem_q[mem_op_i.addr];
    end
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;

endmodule

// ----- src/sst_checker.sv -----
`include "assert_macros.svh"

module sst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic s_xfer;
  logic rd_kind;

  assign s_xfer  = s_axis_tvalid && s_axis_tready;
  assign rd_kind = (m_axis_tuser == sst_pkg::RK_TX_RSP) ||
                   (m_axis_tuser == sst_pkg::RK_LKUP_RSP) ||
                   (m_axis_tuser == sst_pkg::RK_RX_RSP);

  // every input transfer has a result showing once it has passed the input and result registers
  `ASSERT_PROP(a_result_follows, clk_i, rst_ni, s_xfer |-> ##2 m_axis_tvalid, "result missing")
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `ASSERT_NEVER(a_sess_only_release, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != sst_pkg::RK_RELEASE) && (m_axis_tdata[9:0] != '0), "session on non-release")
  `ASSERT_NEVER(a_state_only_read, clk_i, rst_ni, m_axis_tvalid && !rd_kind && (m_axis_tdata[13:10] != '0), "state on non-read result")

endmodule

bind tcp_session_state_table_unit sst_checker u_sst_checker (.*);

// ----- test/tcp_session_state_table_unit_tb.sv -----
module tcp_session_state_table_unit_tb;
  import sst_pkg::*;

  localparam logic [2:0]       KIND_MAX = 3'd7;
  localparam logic [SID_W-1:0] SID_TOP  = SID_W'(SESSIONS - 1);
  localparam logic [ST_W-1:0]  ST_TOP   = '1;
  localparam int               N_RANDOM = 1450;
  localparam int               N_CALM   = 250;

  typedef struct packed {
    res_kind_e        kind;
    logic [SID_W-1:0] sess;
    logic [ST_W-1:0]  state;
  } outcome_t;

  // Shadow of the session table: locks, parking slots and the expected outcome queue
  class session_table_scoreboard;
    logic [ST_W-1:0]  states [SESSIONS];
    logic [SID_W-1:0] tx_lock_sid;
    logic [SID_W-1:0] rx_lock_sid;
    logic [SID_W-1:0] timer_park_sid;
    bit               tx_locked;
    bit               rx_locked;
    bit               tx_park_v;
    bit               rx_park_v;
    bit               timer_park_v;
    req_t             tx_park_req;
    req_t             rx_park_req;
    outcome_t         pending [$];
    int unsigned      n_errors;
    int unsigned      n_items;
    int unsigned      kind_seen [8];

    function new();
      foreach (states[i]) states[i] = ST_CLOSED;
      tx_lock_sid    = '0;
      rx_lock_sid    = '0;
      timer_park_sid = '0;
      tx_park_req    = '0;
      rx_park_req    = '0;
      n_errors       = 0;
      n_items        = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function int unsigned slot(logic [SID_W-1:0] sid);
      return int'(sid) % SESSIONS;
    endfunction

    function outcome_t outcome(res_kind_e k, logic [SID_W-1:0] s = '0,
                               logic [ST_W-1:0] st = '0);
      outcome_t o;
      o.kind  = k;
      o.sess  = s;
      o.state = st;
      return o;
    endfunction

    function bit tx_held_off(logic [SID_W-1:0] sid);
      return rx_locked && rx_lock_sid == sid;
    endfunction

    function bit rx_held_off(logic [SID_W-1:0] sid);
      return tx_locked && tx_lock_sid == sid;
    endfunction

    function outcome_t run_tx(logic [SID_W-1:0] sid, logic wr, logic [ST_W-1:0] st);
      if (wr) begin
        states[slot(sid)] = st;
        tx_locked = 1'b0;
        return outcome(RK_DONE);
      end
      tx_lock_sid = sid;
      tx_locked   = 1'b1;
      return outcome(RK_TX_RSP, '0, states[slot(sid)]);
    endfunction

    function outcome_t run_rx(logic [SID_W-1:0] sid, logic wr, logic [ST_W-1:0] st);
      if (wr) begin
        states[slot(sid)] = st;
        rx_locked = 1'b0;
        if (st == ST_CLOSED) return outcome(RK_RELEASE, sid);
        return outcome(RK_DONE);
      end
      rx_lock_sid = sid;
      rx_locked   = 1'b1;
      return outcome(RK_RX_RSP, '0, states[slot(sid)]);
    endfunction

    function outcome_t run_timer(logic [SID_W-1:0] sid);
      states[slot(sid)] = ST_CLOSED;
      return outcome(RK_RELEASE, sid);
    endfunction

    function outcome_t predict(req_t r);
      case (r.kind)
        KIND_TX_RW: begin
          if (tx_park_v) return outcome(RK_REFUSED);
          if (tx_held_off(r.sid)) begin
            tx_park_req = r;
            tx_park_v   = 1'b1;
            return outcome(RK_PARKED);
          end
          return run_tx(r.sid, r.wr, r.st);
        end
        KIND_TX_LKUP: return outcome(RK_LKUP_RSP, '0, states[slot(r.sid)]);
        KIND_RX_RW: begin
          if (rx_park_v) return outcome(RK_REFUSED);
          if (rx_held_off(r.sid)) begin
            rx_park_req = r;
            rx_park_v   = 1'b1;
            return outcome(RK_PARKED);
          end
          return run_rx(r.sid, r.wr, r.st);
        end
        KIND_TIMER: begin
          if (timer_park_v) return outcome(RK_REFUSED);
          if (tx_held_off(r.sid) || rx_held_off(r.sid)) begin
            timer_park_sid = r.sid;
            timer_park_v   = 1'b1;
            return outcome(RK_PARKED);
          end
          return run_timer(r.sid);
        end
        KIND_IDLE: begin
          // only the first parked source in tx, rx, timer order is retried
          if (tx_park_v) begin
            if (tx_held_off(tx_park_req.sid)) return outcome(RK_PARKED);
            tx_park_v = 1'b0;
            return run_tx(tx_park_req.sid, tx_park_req.wr, tx_park_req.st);
          end
          if (rx_park_v) begin
            if (rx_held_off(rx_park_req.sid)) return outcome(RK_PARKED);
            rx_park_v = 1'b0;
            return run_rx(rx_park_req.sid, rx_park_req.wr, rx_park_req.st);
          end
          if (timer_park_v) begin
            if (tx_held_off(timer_park_sid) || rx_held_off(timer_park_sid))
              return outcome(RK_PARKED);
            timer_park_v = 1'b0;
            return run_timer(timer_park_sid);
          end
          return outcome(RK_DONE);
        end
        default: return outcome(RK_REFUSED);
      endcase
    endfunction

    function void note_input(req_t r);
      pending.push_back(predict(r));
      n_items++;
    endfunction

    function void check_result(logic [2:0] kind, logic [SID_W-1:0] sess,
                               logic [ST_W-1:0] st);
      outcome_t e;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: kind %0d session %0d state %0d",
               kind, sess, st);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (kind !== e.kind) begin
        $error("result_kind mismatch: expected %0d, actual %0d", e.kind, kind);
        n_errors++;
      end
      if (sess !== e.sess) begin
        $error("result_session mismatch: expected %0d, actual %0d", e.sess, sess);
        n_errors++;
      end
      if (st !== e.state) begin
        $error("result_state mismatch: expected %0d, actual %0d", e.state, st);
        n_errors++;
      end
      if (!$isunknown(kind)) kind_seen[kind]++;
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata;
  logic [2:0]        s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;
  logic [2:0]        m_axis_tuser;

  session_table_scoreboard sb;
  bit                      idling_on;
  logic [SID_W-1:0]        sid_pool [8];

  tcp_session_state_table_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_req(logic [2:0] kind, logic [SID_W-1:0] sid, logic wr,
                          logic [ST_W-1:0] st);
    req_t r;
    r.kind = kind;
    r.sid  = sid;
    r.wr   = wr;
    r.st   = st;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {1'b0, st, wr, sid};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(r);
  endtask

  // Lowers tvalid in the step of the last transfer, then waits for every result
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SID_W-1:0] pick_sid();
    if ($urandom_range(0, 6) != 0) return sid_pool[$urandom_range(0, 7)];
    return SID_W'($urandom_range(0, SESSIONS - 1));
  endfunction

  task automatic send_random();
    logic [2:0]       k;
    logic [SID_W-1:0] sid;
    logic             wr;
    logic [ST_W-1:0]  st;
    int unsigned      r;
    r   = $urandom_range(0, 99);
    sid = pick_sid();
    wr  = 1'($urandom_range(0, 1));
    st  = ST_W'($urandom_range(0, 15));
    if (r < 30) begin
      k = KIND_TX_RW;
      // mostly read then write back the locked session
      if ($urandom_range(0, 19) != 0) begin
        if (sb.tx_locked && $urandom_range(0, 3) != 0) begin
          sid = sb.tx_lock_sid;
          wr  = 1'b1;
        end else begin
          wr = 1'b0;
        end
      end
    end else if (r < 36) begin
      k = KIND_TX_LKUP;
    end else if (r < 66) begin
      k = KIND_RX_RW;
      if ($urandom_range(0, 19) != 0) begin
        if (sb.rx_locked && $urandom_range(0, 3) != 0) begin
          sid = sb.rx_lock_sid;
          wr  = 1'b1;
        end else begin
          wr = 1'b0;
        end
      end
      if (wr && $urandom_range(0, 2) == 0) st = ST_CLOSED;
    end else if (r < 76) begin
      k = KIND_TIMER;
    end else if (r < 96) begin
      k = KIND_IDLE;
    end else begin
      k = 3'($urandom_range(KIND_IDLE + 1, KIND_MAX));
    end
    // keep both sides from parking on each other, which would lock up for good
    if (k == KIND_TX_RW && !sb.tx_park_v && sb.rx_park_v && sb.tx_held_off(sid))
      sid = sid + 1'b1;
    if (k == KIND_RX_RW && !sb.rx_park_v && sb.tx_park_v && sb.rx_held_off(sid))
      sid = sid + 1'b1;
    send_req(k, sid, wr, st);
  endtask

  // Writes from both sides clear the locks, idle ticks flush the parked requests
  task automatic clear_locks();
    int n;
    n = 0;
    while ((sb.tx_park_v || sb.rx_park_v || sb.tx_locked || sb.rx_locked) && n < 32) begin
      if (!sb.rx_park_v)
        send_req(KIND_RX_RW, sb.tx_lock_sid + 1'b1, 1'b1, ST_W'($urandom_range(1, 15)));
      if (!sb.tx_park_v)
        send_req(KIND_TX_RW, sb.rx_lock_sid + 1'b1, 1'b1, ST_W'($urandom_range(1, 15)));
      send_req(KIND_IDLE, '0, 1'b0, '0);
      n++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tuser, m_axis_tdata[SID_W-1:0],
                      m_axis_tdata[SID_W+ST_W-1:SID_W]);
  end

  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #6_000_000;
    $display("tcp_session_state_table_unit verification failed");
    $finish;
  end

  initial begin
    int               i;
    int               k;
    int unsigned      waited;
    logic [SID_W-1:0] sa;
    logic [SID_W-1:0] sb_sid;
    sb = new();
    idling_on = 1'b1;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    sid_pool[0] = '0;
    sid_pool[1] = SID_TOP;
    for (i = 2; i < 8; i++) sid_pool[i] = SID_W'($urandom_range(0, SESSIONS - 1));
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, locking, parking, refusal and retry order
    send_req(KIND_TX_LKUP, '0, 1'b0, '0);
    send_req(KIND_TX_RW, SID_TOP, 1'b1, ST_TOP);
    send_req(KIND_TX_LKUP, SID_TOP, 1'b0, '0);
    send_req(KIND_TX_RW, SID_TOP, 1'b0, '0);         // tx lock on top session
    send_req(KIND_RX_RW, SID_TOP, 1'b1, 4'd5);       // parks behind tx lock
    send_req(KIND_RX_RW, 10'd3, 1'b0, '0);           // rx already parked
    send_req(KIND_TIMER, SID_TOP, 1'b0, '0);         // timer parks
    send_req(KIND_TIMER, SID_TOP, 1'b0, '0);         // timer already parked
    send_req(KIND_IDLE, '0, 1'b0, '0);               // still blocked
    send_req(KIND_TX_RW, SID_TOP, 1'b1, 4'd9);       // releases tx lock
    send_req(KIND_IDLE, '0, 1'b0, '0);               // rx retry goes through
    send_req(KIND_IDLE, '0, 1'b0, '0);               // timer retry releases
    send_req(KIND_IDLE, '0, 1'b0, '0);               // nothing parked
    send_req(KIND_RX_RW, 10'd512, 1'b0, '0);         // rx lock
    send_req(KIND_TX_RW, 10'd512, 1'b0, '0);         // tx parks behind rx lock
    send_req(KIND_TX_RW, 10'd7, 1'b0, '0);           // tx already parked
    send_req(KIND_RX_RW, 10'd512, 1'b1, ST_CLOSED);  // release
    send_req(KIND_IDLE, '0, 1'b0, '0);               // tx retry read
    send_req(KIND_TX_RW, '0, 1'b1, 4'hA);            // write elsewhere still unlocks
    for (k = KIND_IDLE + 1; k <= KIND_MAX; k++)
      send_req(3'(k), SID_W'($urandom_range(0, SESSIONS - 1)), 1'b1, ST_TOP);
    send_req(KIND_RX_RW, '0, 1'b1, ST_CLOSED);
    send_req(KIND_TIMER, 10'd682, 1'b1, 4'd6);
    wait_drained();

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - N_CALM) idling_on = 1'b0;
      send_random();
    end

    // finally both sides parked on each other's locks: permanent lock-up
    clear_locks();
    sa     = SID_W'($urandom_range(0, SESSIONS - 1));
    sb_sid = sa ^ SID_W'($urandom_range(1, SESSIONS - 1));
    send_req(KIND_TX_RW, sa, 1'b0, '0);
    send_req(KIND_RX_RW, sb_sid, 1'b0, '0);
    send_req(KIND_TX_RW, sb_sid, 1'b1, 4'd3);
    send_req(KIND_RX_RW, sa, 1'b0, '0);
    send_req(KIND_IDLE, '0, 1'b0, '0);
    send_req(KIND_TX_RW, sa, 1'b1, 4'd4);
    send_req(KIND_RX_RW, sb_sid, 1'b1, ST_CLOSED);
    send_req(KIND_TIMER, sa, 1'b0, '0);
    send_req(KIND_TIMER, sb_sid, 1'b0, '0);
    send_req(KIND_IDLE, '0, 1'b0, '0);
    send_req(KIND_IDLE, '0, 1'b0, '0);
    send_req(KIND_TX_LKUP, sa, 1'b0, '0);
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d results never arrived", sb.pending.size());
      sb.n_errors++;
    end

    $display("Covered %0d requests: %0d read rsp, %0d lookups, %0d releases, %0d done",
             sb.n_items, sb.kind_seen[RK_TX_RSP] + sb.kind_seen[RK_RX_RSP],
             sb.kind_seen[RK_LKUP_RSP], sb.kind_seen[RK_RELEASE], sb.kind_seen[RK_DONE]);
    $display("  %0d parked, %0d refused, idling on both sides, mutual parking at the end",
             sb.kind_seen[RK_PARKED], sb.kind_seen[RK_REFUSED]);
    if (sb.n_errors == 0)
      $display("tcp_session_state_table_unit verification clean");
    else
      $display("tcp_session_state_table_unit verification failed");
    $finish;
  end

endmodule
